### rtl/sapq_pkg.sv
// shared types, codes and defaults for the sorted array priority queue
package sapq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int KEY_W     = 32;
	localparam int OCC_W     = 5;

	// request kinds
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_NOTFOUND  = 2'd3;

	// cell operation codes
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_INS   = 2'd1;
	localparam logic [1:0] OP_DEL   = 2'd2;

	typedef struct packed {
		logic                    req_type;
		logic signed [KEY_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [OCC_W-1:0]        occupancy;
		logic signed [KEY_W-1:0] largest_value;
	} rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic [1:0]              op;
		logic signed [KEY_W-1:0] value;
	} cell_cmd_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic                    valid;
		logic                    gt;
		logic                    eq;
		logic signed [KEY_W-1:0] entry;
	} cell_out_t;

endpackage

### rtl/sapq_cell.sv
// one slot of the sorted row: holds a key and moves it to or from its neighbors
module sapq_cell
	import sapq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  cell_out_t left,
	input  logic      left_first,
	input  cell_out_t right,
	output cell_out_t self
);

	logic                    valid_q;
	logic signed [KEY_W-1:0] entry_q;
	logic                    gt;
	logic                    left_gt;

	assign gt      = valid_q && (entry_q > cmd.value);
	assign left_gt = left_first || left.gt;

	assign self.valid = valid_q;
	assign self.gt    = gt;
	assign self.eq    = valid_q && (entry_q == cmd.value);
	assign self.entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_INS: begin
					// filled by the new key or by the key moving down from the left
					if (!gt) valid_q <= left_gt || left.valid;
				end
				OP_DEL: begin
					if (!gt) valid_q <= right.valid;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_INS: begin
				// new key lands at the first slot not greater than it
				if (!gt) entry_q <= left_gt ? cmd.value : left.entry;
			end
			OP_DEL: begin
				// close the gap from the matching slot onward
				if (!gt) entry_q <= right.entry;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/sorted_array_priority_queue.sv
// top level: row of compare-and-shift cells holding keys in descending order
// result is valid in the cycle after the request transaction is accepted
// throughput: one request per cycle while req_stall is low; every cell compares
// to the broadcast key and updates in parallel; or-reduced match flags decide a delete
// reset (arst_n low, asynchronous): queue empty, no result pending
// key storage itself is not cleared; per-slot valid bits mask it
module sorted_array_priority_queue
	import sapq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	cell_cmd_t             cmd;
	cell_out_t [DEPTH-1:0] cells;
	cell_out_t             empty_cell;
	logic [DEPTH-1:0]      eq_vec;
	logic                  found;
	logic                  accept;
	logic                  full;
	logic                  empty;
	logic [CNT_W-1:0]      count_q;
	logic [1:0]            status_q;
	logic                  rsp_valid_q;
	logic [1:0]            status_d;

	// a new request waits only while a finished result is held back
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// any stored copy of the key
	always_comb begin
		for (int i = 0; i < DEPTH; i++) eq_vec[i] = cells[i].eq;
	end
	assign found = |eq_vec;

	// decide status and what the cells do this cycle
	always_comb begin
		cmd.value = req.value;
		cmd.op    = OP_NONE;
		status_d  = ST_OK;
		if (req.req_type == REQ_INSERT) begin
			if (full) status_d = ST_OVERFLOW;
			else if (accept) cmd.op = OP_INS;
		end else begin
			if (empty) status_d = ST_UNDERFLOW;
			else if (!found) status_d = ST_NOTFOUND;
			else if (accept) cmd.op = OP_DEL;
		end
	end

	assign empty_cell = '{valid: 1'b0, gt: 1'b0, eq: 1'b0, entry: '0};

	// cell row: cell 0 is the head, each cell sees its two neighbors
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		cell_out_t left_n;
		cell_out_t right_n;
		if (g == 0) begin : g_head
			assign left_n = empty_cell;
		end else begin : g_mid
			assign left_n = cells[g-1];
		end
		if (g == DEPTH - 1) begin : g_tail
			assign right_n = empty_cell;
		end else begin : g_body
			assign right_n = cells[g+1];
		end
		sapq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left       (left_n),
			.left_first (g == 0),
			.right      (right_n),
			.self       (cells[g])
		);
	end

	// occupancy and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= accept || (rsp_valid_q && rsp_stall);
			if (cmd.op == OP_INS) count_q <= count_q + CNT_W'(1);
			else if (cmd.op == OP_DEL) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) status_q <= status_d;
	end

	// cells and count stay put while a result is pending, so the head is read live
	assign rsp_valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.occupancy     = OCC_W'(count_q);
	assign rsp.largest_value = cells[0].valid ? cells[0].entry : '0;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the sorted array priority queue
module tb_top;
	import sapq_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 250000;
	localparam int MAX_GAP     = 18;
	localparam int DRAIN_WAIT  = 8;

	// scoreboard: own copy of the sorted keys, expected responses in order
	class pq_scoreboard;
		logic signed [KEY_W-1:0] keys[DEPTH];
		int unsigned             key_count;
		rsp_t                    expected_rsp[$];
		int                      error_count;

		function new();
			key_count   = 0;
			error_count = 0;
			foreach (keys[i]) keys[i] = '0;
		endfunction

		// apply one request to the local copy and return what the block must answer
		function rsp_t apply_request(req_t r);
			rsp_t res;
			int   pos;
			pos = 0;
			res.status = ST_OK;
			if (r.req_type == REQ_INSERT) begin
				if (key_count >= DEPTH) begin
					res.status = ST_OVERFLOW;
				end else begin
					// newest among equal keys goes first
					while (pos < key_count && keys[pos] > r.value) pos++;
					for (int j = key_count; j > pos; j--) keys[j] = keys[j-1];
					keys[pos] = r.value;
					key_count++;
				end
			end else begin
				if (key_count == 0) begin
					res.status = ST_UNDERFLOW;
				end else begin
					while (pos < key_count && keys[pos] != r.value) pos++;
					if (pos >= key_count) begin
						res.status = ST_NOTFOUND;
					end else begin
						for (int j = pos; j + 1 < key_count; j++) keys[j] = keys[j+1];
						key_count--;
						keys[key_count] = '0;
					end
				end
			end
			res.occupancy     = key_count[OCC_W-1:0];
			res.largest_value = (key_count > 0) ? keys[0] : '0;
			return res;
		endfunction

		function void note_request(req_t r);
			expected_rsp.push_back(apply_request(r));
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		// a key that is stored now, so a delete will hit
		function logic signed [KEY_W-1:0] pick_stored();
			if (key_count == 0) return $urandom;
			return keys[$urandom_range(0, key_count - 1)];
		endfunction

		task report(string what);
			error_count++;
			$display("mismatch @%0t: %s", $realtime, what);
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				report($sformatf("response with no request pending (status %0d)", got.status));
			end else begin
				want = expected_rsp.pop_front();
				if (got.status !== want.status)
					report($sformatf("status got %0d want %0d", got.status, want.status));
				if (got.occupancy !== want.occupancy)
					report($sformatf("occupancy got %0d want %0d",
						got.occupancy, want.occupancy));
				if (got.largest_value !== want.largest_value)
					report($sformatf("largest_value got %0d want %0d",
						got.largest_value, want.largest_value));
			end
		endtask
	endclass

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	pq_scoreboard sb = new();

	// knobs shared by the driver processes
	bit req_idle_on  = 1'b0;
	bit rsp_idle_on  = 1'b0;
	int rsp_hold     = 0;
	int cycle_count  = 0;

	sorted_array_priority_queue #(
		.DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: the run must end well inside the cycle budget
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sorted_array_priority_queue regression: fail");
			$finish;
		end
	end

	// response monitor: a transaction completes when valid is high and stall is low
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	// idle draw: mostly short gaps, now and then a long one, none when idling is off
	function int draw_gap(bit on);
		if (!on) return 0;
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, MAX_GAP);
		return $urandom_range(0, 2);
	endfunction

	// key pool: many small keys so duplicates and hits are common, plus extremes
	function logic signed [KEY_W-1:0] draw_key();
		case ($urandom_range(0, 9))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2, 3:    return $urandom;
			default: return $signed($urandom_range(0, 16)) - 8;
		endcase
	endfunction

	function req_t make_request(int insert_pct);
		req_t r;
		r.req_type = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_DELETE;
		if (r.req_type == REQ_DELETE && $urandom_range(0, 9) < 7)
			r.value = sb.pick_stored();
		else
			r.value = draw_key();
		return r;
	endfunction

	// offer one request transaction; valid stays up across back-to-back items
	task automatic send(req_t item);
		int gap;
		gap = draw_gap(req_idle_on);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		sb.note_request(item);
	endtask

	task automatic send_op(logic kind, logic signed [KEY_W-1:0] key);
		req_t r;
		r.req_type = kind;
		r.value    = key;
		send(r);
	endtask

	// sender pause: nothing new until every expected response is back
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// receiver: random stall before each response, long hold-off on request
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rsp_hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (rsp_hold) @(posedge clk);
				rsp_hold = 0;
			end else begin
				gap = draw_gap(rsp_idle_on);
				if (gap > 0) begin
					rsp_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid && rsp_hold == 0);
		end
	end

	initial begin
		int insert_pct[7] = '{65, 50, 35, 80, 50, 20, 55};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty delete, extremes, duplicates, absent key, fill past full
		send_op(REQ_DELETE, 32'sd0);
		send_op(REQ_INSERT, 32'sh7fffffff);
		send_op(REQ_INSERT, 32'sh80000000);
		send_op(REQ_INSERT, 32'sd0);
		send_op(REQ_INSERT, -32'sd1);
		send_op(REQ_INSERT, 32'sd1);
		send_op(REQ_INSERT, 32'sd5);
		send_op(REQ_INSERT, 32'sd5);
		send_op(REQ_DELETE, 32'sd5);
		send_op(REQ_DELETE, 32'sd123);
		for (int i = 0; i < 10; i++)
			send_op(REQ_INSERT, $signed(i * 37) - 150);
		// queue is full here, this one must be rejected
		send_op(REQ_INSERT, 32'sd9);
		send_op(REQ_DELETE, 32'sh80000000);
		send_op(REQ_DELETE, 32'sh7fffffff);
		drain();

		// random phases with different idle patterns and insert/delete balance
		for (int ph = 0; ph < 7; ph++) begin
			req_idle_on = ph[0];
			rsp_idle_on = ph[1];
			if (ph == 3) begin
				// receiver holds off while requests keep coming, so the block backs up
				req_idle_on = 1'b0;
				rsp_hold    = 150;
			end
			for (int n = 0; n < 100; n++)
				send(make_request(insert_pct[ph]));
			drain();
		end

		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.error_count == 0 && sb.pending() == 0) begin
			$display("sorted_array_priority_queue regression: pass");
		end else begin
			$display("sorted_array_priority_queue regression: fail");
		end
		$finish;
	end

endmodule
